// File: rtl/gcd_lcm_unit_defines.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit assertion macros
// Shared concurrent assertion forms for the gcd/lcm unit, all clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_pkg
// Widths and controller/datapath interface types of the gcd/lcm unit.
// ----------------------------------------------------------------------------
package gcl_pkg;

    // Operand magnitude width; operand ports carry 32 bits, the low WIDTH are used.
    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int OPND_W  = 32;
    localparam int VALUE_W = 64;

    typedef struct packed {
        logic load;      // capture operands and mode
        logic gcd_step;  // one binary gcd reduction step
        logic fix;       // form the gcd, set the result (gcd, or 0 in lcm mode), prime the divider
        logic div_step;  // one restoring division step
        logic mul;       // form the lcm product
    } cmd_t;

    typedef struct packed {
        logic gcd_done;  // one of the reduced operands is zero
        logic div_last;  // the current division step is the final one
        logic mode;      // captured mode bit
        logic zero_op;   // one of the captured operands is zero
    } status_t;

endpackage

// File: rtl/gcl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_datapath
// Binary gcd reducer, restoring divider and product register of the unit.
// ----------------------------------------------------------------------------
`include "gcd_lcm_unit_defines.svh"

module gcl_datapath
    import gcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                mode,
    input  logic [OPND_W-1:0]   operand_a,
    input  logic [OPND_W-1:0]   operand_b,
    output logic [VALUE_W-1:0]  value
);

    logic [WIDTH-1:0]   a_reg, b_reg;
    logic               mode_reg;
    logic [WIDTH-1:0]   x_reg, x_next;
    logic [WIDTH-1:0]   y_reg, y_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [WIDTH-1:0]   g_reg;
    logic [WIDTH-1:0]   g_calc;
    logic [WIDTH-1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WIDTH:0]     trial;
    logic [2*WIDTH-1:0] prod;
    logic [VALUE_W-1:0] result_reg;

    // Once one operand is zero the other holds the gcd with its common twos stripped.
    assign g_calc = (x_reg | y_reg) << k_reg;

    // Binary gcd: strip common twos, strip lone twos, subtract odd from odd.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        if (!x_reg[0] && !y_reg[0])
        begin
            x_next = x_reg >> 1;
            y_next = y_reg >> 1;
            k_next = k_reg + CNT_W'(1);
        end
        else if (!x_reg[0])
        begin
            x_next = x_reg >> 1;
        end
        else if (!y_reg[0])
        begin
            y_next = y_reg >> 1;
        end
        else if (x_reg >= y_reg)
        begin
            x_next = x_reg - y_reg;
        end
        else
        begin
            y_next = y_reg - x_reg;
        end
    end

    // Restoring division of a by the gcd, one quotient bit per cycle.
    assign trial = {rem_reg, quot_reg[WIDTH-1]};

    always_comb
    begin
        if (trial >= {1'b0, g_reg})
        begin
            rem_next  = WIDTH'(trial - {1'b0, g_reg});
            quot_next = {quot_reg[WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next  = trial[WIDTH-1:0];
            quot_next = {quot_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign prod = quot_reg * b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= operand_a[WIDTH-1:0];
            b_reg    <= operand_b[WIDTH-1:0];
            x_reg    <= operand_a[WIDTH-1:0];
            y_reg    <= operand_b[WIDTH-1:0];
            mode_reg <= mode;
            k_reg    <= '0;
        end
        else if (cmd.gcd_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            k_reg <= k_next;
        end

        if (cmd.fix)
        begin
            g_reg      <= g_calc;
            rem_reg    <= '0;
            quot_reg   <= a_reg;
            cnt_reg    <= CNT_W'(WIDTH - 1);
            result_reg <= mode_reg ? '0 : VALUE_W'(g_calc);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.mul)
        begin
            result_reg <= VALUE_W'(prod);
        end
    end

    always_comb
    begin
        status.gcd_done = (x_reg == '0) || (y_reg == '0);
        status.div_last = (cnt_reg == '0);
        status.mode     = mode_reg;
        status.zero_op  = (a_reg == '0) || (b_reg == '0);
    end

    assign value = result_reg;

    `GCL_ASSERT_SAME(a_div_nonzero_divisor, cmd.div_step, g_reg != '0, "division by a zero gcd")
    `GCL_ASSERT_SAME(a_div_rem_bound, cmd.div_step, rem_reg < g_reg, "partial remainder out of range")
    `GCL_ASSERT_NEXT(a_fix_primes_div, cmd.fix, rem_reg == '0 && cnt_reg == CNT_W'(WIDTH - 1), "divider not primed")

endmodule

// File: rtl/gcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_ctrl
// Sequencer of the gcd/lcm unit: gcd loop, optional division and product.
// ----------------------------------------------------------------------------
`include "gcd_lcm_unit_defines.svh"

module gcl_ctrl
    import gcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.fix = 1'b1;
                    // The gcd is final here; the lcm of a zero operand is zero.
                    if (!status.mode || status.zero_op)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `GCL_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted transaction did not start")
    `GCL_ASSERT_NEXT(a_done_releases, done, !busy, "unit stayed busy after its result")
    `GCL_ASSERT_SAME(a_mul_after_div, state_reg == S_MUL, $past(state_reg) == S_DIV, "product without division")

endmodule

// File: rtl/gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor (mode 0) or least common multiple (mode 1) of two
// unsigned WIDTH-bit magnitudes, with a full double-width lcm.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low; busy then stays
// high until the result has been shown. done is high for exactly one cycle and
// marks the result on value; it must be captured then since the unit cannot be
// stalled. The gcd comes from a binary reduction loop that handles one bit or
// one subtraction per cycle, so its length depends on the operands. The fix step
// that ends the loop registers a gcd result, which is shown in the done state.
// An lcm with nonzero operands adds a restoring division of the first operand by
// the gcd, one quotient bit for each operand bit, and then the 32x32 product;
// an lcm with a zero operand returns 0 as fast as a gcd.
// A new transaction can be taken in the cycle after done.
// ----------------------------------------------------------------------------

module gcd_lcm_unit
    import gcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               mode,
    input  logic [OPND_W-1:0]  operand_a,
    input  logic [OPND_W-1:0]  operand_b,
    output logic [VALUE_W-1:0] value
);

    cmd_t    cmd;
    status_t status;

    gcl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    gcl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .value     (value)
    );

endmodule
